### hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with saturating scale.
// Holds opcodes, payload structs and the controller/datapath command and status structs.
// No dependencies.
package bdq_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned OP_W    = 3;

   localparam logic [WORD_W-1:0] INT_MAX         = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] POP_EMPTY_VALUE = 32'hFFFF_FFFF;

   // opcode values 6 and 7 are unused and act as no operation
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_SCALE_ALL  = 3'd5
   } bdq_op_type;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic signed [WORD_W-1:0] push_value;
   } bdq_req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic                     was_empty;
      logic                     was_full;
      logic [COUNT_W-1:0]       entry_count;
   } bdq_rsp_type;

   typedef struct packed {
      logic take_item;   // latch the accepted word
      logic push;        // store the held word, move index/count
      logic pop_read;    // issue the store read for a pop
      logic pop_done;    // retire the pop, move index/count
      logic clear;       // empty the queue
      logic scan_start;  // read the first entry of a scale walk
      logic scan_read;   // read the next entry of a scale walk
      logic respond;     // load the result register
   } bdq_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] opcode;
      logic            empty;
      logic            full;
      logic            single;
      logic            scan_last;
      logic            out_free;
   } bdq_status_type;

endpackage

### hw/rtl/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bdq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bdq_ctrl.sv
// Sequencing state machine of the deque: accepts words and steps the datapath.
// Depends on bdq_pkg.
module bdq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bdq_pkg::bdq_status_type status,
   output bdq_pkg::bdq_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_WAIT,
      S_SCAN,
      S_SCAN_END
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (status.opcode)
               bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                  if (status.out_free) begin
                     cmd.push    = !status.full;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
               bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                  if (status.empty) begin
                     if (status.out_free) begin
                        cmd.respond = 1'b1;
                        state_in    = S_IDLE;
                     end
                  end else begin
                     cmd.pop_read = 1'b1;
                     state_in     = S_POP_WAIT;
                  end
               end
               bdq_pkg::OP_CLEAR: begin
                  if (status.out_free) begin
                     cmd.clear   = 1'b1;
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
               bdq_pkg::OP_SCALE_ALL: begin
                  if (status.empty) begin
                     if (status.out_free) begin
                        cmd.respond = 1'b1;
                        state_in    = S_IDLE;
                     end
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = status.single ? S_SCAN_END : S_SCAN;
                  end
               end
               default: begin
                  if (status.out_free) begin
                     cmd.respond = 1'b1;
                     state_in    = S_IDLE;
                  end
               end
            endcase
         end
         S_POP_WAIT: begin
            if (status.out_free) begin
               cmd.pop_done = 1'b1;
               cmd.respond  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
            if (status.scan_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            if (status.out_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/bdq_dp.sv
// Datapath of the deque: ring indexes, entry store, scale unit and result register.
// Depends on bdq_pkg and bdq_ram.
module bdq_dp #(
   parameter int unsigned DEPTH       = 64,
   parameter int unsigned SCALE_SHIFT = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bdq_pkg::bdq_req_type    req_data,
   input  bdq_pkg::bdq_cmd_type    cmd,
   output bdq_pkg::bdq_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bdq_pkg::bdq_rsp_type    rsp_data
);

   localparam int unsigned IW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [bdq_pkg::WORD_W-1:0] SAT_LIMIT = bdq_pkg::INT_MAX >> SCALE_SHIFT;

   function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                              input logic [CW-1:0] offset);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(offset);
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   function automatic logic [bdq_pkg::WORD_W-1:0] scale_word(
      input logic [bdq_pkg::WORD_W-1:0] w);
      if (!w[bdq_pkg::WORD_W-1] && (w > SAT_LIMIT)) begin
         return bdq_pkg::INT_MAX;
      end
      return w << SCALE_SHIFT;
   endfunction

   logic [bdq_pkg::OP_W-1:0]          op_ff;
   logic signed [bdq_pkg::WORD_W-1:0] value_ff;
   logic [IW-1:0]                     front_ff, front_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     scan_idx_ff, scan_idx_in;
   logic                              scan_pend_ff, scan_pend_in;
   logic [IW-1:0]                     scan_addr_ff, scan_addr_in;
   bdq_pkg::bdq_rsp_type              rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   logic                              is_push, is_pop, is_front;
   logic                              empty, full;
   logic [IW-1:0]                     front_dec;
   logic [IW-1:0]                     back_pos;
   logic [IW-1:0]                     last_pos;
   logic [CW-1:0]                     count_dec;
   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic [bdq_pkg::WORD_W-1:0]        wr_data;
   logic                              rd_en;
   logic [IW-1:0]                     rd_addr;
   logic [IW-1:0]                     scan_pos;
   logic [bdq_pkg::WORD_W-1:0]        rd_data;

   assign is_push  = (op_ff == bdq_pkg::OP_PUSH_FRONT) || (op_ff == bdq_pkg::OP_PUSH_BACK);
   assign is_pop   = (op_ff == bdq_pkg::OP_POP_FRONT) || (op_ff == bdq_pkg::OP_POP_BACK);
   assign is_front = (op_ff == bdq_pkg::OP_PUSH_FRONT) || (op_ff == bdq_pkg::OP_POP_FRONT);
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(DEPTH));

   assign count_dec = count_ff - CW'(1);
   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - IW'(1);
   assign back_pos  = ring_pos(front_ff, count_ff);
   assign last_pos  = ring_pos(front_ff, count_dec);
   assign scan_pos  = ring_pos(front_ff, cmd.scan_start ? CW'(0) : scan_idx_ff);

   assign status.opcode    = op_ff;
   assign status.empty     = empty;
   assign status.full      = full;
   assign status.single    = (count_ff == CW'(1));
   assign status.scan_last = (scan_idx_ff == count_dec);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // write port: push, or write back the scaled word read on the previous cycle
   always_comb begin
      wr_en   = cmd.push || scan_pend_ff;
      wr_addr = scan_addr_ff;
      wr_data = scale_word(rd_data);
      if (cmd.push) begin
         wr_addr = is_front ? front_dec : back_pos;
         wr_data = value_ff;
      end
   end

   assign rd_en   = cmd.pop_read || cmd.scan_start || cmd.scan_read;
   assign rd_addr = cmd.pop_read ? (is_front ? front_ff : last_pos) : scan_pos;

   bdq_ram #(
      .WIDTH (bdq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      front_in     = front_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      scan_pend_in = cmd.scan_start || cmd.scan_read;
      scan_addr_in = scan_pos;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
         if (is_front) begin
            front_in = front_dec;
         end
      end
      if (cmd.pop_done) begin
         count_in = count_dec;
         if (is_front) begin
            front_in = ring_pos(front_ff, CW'(1));
         end
      end
      if (cmd.clear) begin
         count_in = '0;
         front_in = '0;
      end
      if (cmd.scan_start) begin
         scan_idx_in = CW'(1);
      end else if (cmd.scan_read) begin
         scan_idx_in = scan_idx_ff + CW'(1);
      end
   end

   // result word, built from the count after the operation
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (cmd.respond) begin
         rsp_valid_in        = 1'b1;
         rsp_in.popped_value = '0;
         if (cmd.pop_done) begin
            rsp_in.popped_value = rd_data;
         end else if (is_pop && empty) begin
            rsp_in.popped_value = bdq_pkg::POP_EMPTY_VALUE;
         end
         rsp_in.was_empty   = is_pop && empty;
         rsp_in.was_full    = is_push && full;
         rsp_in.entry_count = bdq_pkg::COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         scan_pend_ff <= scan_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         op_ff    <= req_data.opcode;
         value_ff <= req_data.push_value;
      end
      scan_addr_ff <= scan_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/bounded_deque_with_saturating_scale_unit.sv
// Bounded deque of signed 32-bit words with saturating scale-all; one result word per request.
// Pops read the entry store through its registered read port before they respond; scale-all
// reads, scales and writes back every stored entry before it responds.
// Next request is taken once the previous result is loaded into the output register.
// Reset (synchronous, high) empties the queue and drops a pending result; the entry store
// keeps its contents. Depends on bdq_pkg, bdq_ctrl, bdq_dp, bdq_ram.
module bounded_deque_with_saturating_scale_unit #(
   parameter int unsigned DEPTH       = 64,
   parameter int unsigned SCALE_SHIFT = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bdq_pkg::bdq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bdq_pkg::bdq_rsp_type rsp_data
);

   // Controller talks to the datapath only through these two structs.
   bdq_pkg::bdq_cmd_type    cmd;
   bdq_pkg::bdq_status_type status;

   // Sequencer: takes a request word in idle, then steps push, pop, clear
   // or the scale walk, and finishes by loading the result register once
   // that register is free (empty, or being taken in the same cycle).
   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: the ring lives in a RAM of DEPTH words addressed from the
   // front index plus an offset. The scale walk reads one entry per cycle
   // and writes the scaled word back in the following cycle, so reads and
   // writes overlap.
   bdq_dp #(
      .DEPTH       (DEPTH),
      .SCALE_SHIFT (SCALE_SHIFT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/bdq_checker.sv
// Port-level checks for the deque top level, attached by the bind at the end.
// Depends on bdq_pkg and bounded_deque_with_saturating_scale_unit.
module bdq_checker #(
   parameter int unsigned DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input bdq_pkg::bdq_rsp_type rsp_data
);

   // no result survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed");

   // an empty pop reports the -1 marker
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.was_empty) |->
         (rsp_data.popped_value == bdq_pkg::POP_EMPTY_VALUE))
      else $error("empty pop without -1 marker");

   // a word cannot be both an empty pop and a dropped push
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.was_empty && rsp_data.was_full))
      else $error("empty and full flags both set");

   // a dropped push reports a full queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.was_full) |->
         (rsp_data.entry_count == bdq_pkg::COUNT_W'(DEPTH)))
      else $error("dropped push with queue not full");

endmodule

bind bounded_deque_with_saturating_scale_unit bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
